### src/crc16_crc32_byte_engine_assert.svh
// Assertion macros used by the CRC engine core RTL
`ifndef CRC16_CRC32_BYTE_ENGINE_ASSERT_SVH
`define CRC16_CRC32_BYTE_ENGINE_ASSERT_SVH

// same-cycle implication
`define CRCBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRCBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/crcbe_pkg.sv
// Types, register codes and the byte fold function for the CRC engine
package crcbe_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_POLY  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    typedef struct packed {
        logic [31:0] crc_polynomial;
        logic        width_select;
    } crc_cfg_t;

    // MSB-first fold of one byte; 16-bit mode runs left-aligned in the 32-bit datapath
    function automatic logic [31:0] crc_fold(
        input logic [31:0] acc,
        input logic [7:0]  data,
        input logic [31:0] poly,
        input logic        wide
    );
        logic [31:0] c;
        logic [31:0] p;
        c = wide ? (acc ^ {data, 24'h0}) : {acc[15:0] ^ {data, 8'h0}, 16'h0};
        p = wide ? poly : {poly[15:0], 16'h0};
        for (int k = 0; k < 8; k++)
        begin
            c = {c[30:0], 1'b0} ^ (c[31] ? p : 32'h0);
        end
        return wide ? c : {16'h0, c[31:16]};
    endfunction

endpackage

### src/crcbe_if.sv
// Valid/ready stream interfaces for the byte input and CRC result channels
interface crcbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcbe_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;
    logic        message_done;

    modport source (output valid, output crc_value, output message_done, input ready);
    modport sink (input valid, input crc_value, input message_done, output ready);
endinterface

### src/crcbe_cfg_regs.sv
// APB configuration registers: polynomial and width select
module crcbe_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crcbe_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [crcbe_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [crcbe_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output crcbe_pkg::crc_cfg_t               cfg
);

    logic [31:0] poly_reg;
    logic        width_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg  <= 32'h0;
            width_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                crcbe_pkg::REG_POLY:  poly_reg  <= pwdata;
                crcbe_pkg::REG_WIDTH: width_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            crcbe_pkg::REG_POLY:  prdata = poly_reg;
            crcbe_pkg::REG_WIDTH: prdata = {31'h0, width_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.crc_polynomial = poly_reg;
    assign cfg.width_select   = width_reg;

endmodule

### src/crcbe_core.sv
// Input register, byte fold with running accumulator, and result register
`include "crc16_crc32_byte_engine_assert.svh"

module crcbe_core (
    input  logic                clk,
    input  logic                rst_n,
    input  crcbe_pkg::crc_cfg_t cfg,
    crcbe_in_if.sink            byte_in,
    crcbe_out_if.source         crc_out
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        out_valid_reg;
    logic [31:0] crc_reg;
    logic        done_reg;
    logic [31:0] acc_reg;
    logic [31:0] crc_next;
    logic        s1_adv;
    logic        in_take;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || crc_out.ready);
    assign in_take  = byte_in.valid && byte_in.ready;
    assign byte_in.ready = !s1_valid_reg || s1_adv;

    assign crc_next = crcbe_pkg::crc_fold(acc_reg, s1_byte_reg, cfg.crc_polynomial,
                                          cfg.width_select);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 32'h0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= s1_last_reg ? 32'h0 : crc_next;
            end
            else if (crc_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.last_byte;
        end
        if (s1_adv)
        begin
            crc_reg  <= crc_next;
            done_reg <= s1_last_reg;
        end
    end

    assign crc_out.valid        = out_valid_reg;
    assign crc_out.crc_value    = crc_reg;
    assign crc_out.message_done = done_reg;

    `CRCBE_ASSERT_NEXT(a_acc_clear, clk, rst_n, s1_adv && s1_last_reg, acc_reg == 32'h0,
        "accumulator not cleared after last beat")
    `CRCBE_ASSERT_NEXT(a_acc_follow, clk, rst_n, s1_adv && !s1_last_reg, acc_reg == crc_reg,
        "accumulator differs from delivered CRC")
    `CRCBE_ASSERT_NEXT(a_narrow_top, clk, rst_n, s1_adv && !cfg.width_select,
        crc_reg[31:16] == 16'h0, "16-bit CRC has upper bits set")
    `CRCBE_ASSERT_NOW(a_ready_empty, clk, rst_n, !s1_valid_reg, byte_in.ready,
        "input not ready with empty stage")

endmodule

### src/crc16_crc32_byte_engine.sv
// Top level of the configurable MSB-first CRC-16/CRC-32 byte engine
// Usage:
//   byte_in  : valid/ready channel, one message byte per beat plus a last flag.
//   crc_out  : valid/ready channel, one beat per input byte carrying the running
//              CRC after that byte; message_done marks the final CRC of a message.
//   APB port : reg 0 (0x0) polynomial without leading bit, reg 1 (0x4) width
//              select (0 = 16-bit using poly[15:0], 1 = 32-bit). Write only while idle.
// Path: a byte accepted on byte_in is held in the input register, then folded
//   into the result register.
// Throughput: one byte per cycle while crc_out is taken; the 8-step fold against the
//   accumulator completes within the single stage between input and result registers.
// CRC starts at zero, no final XOR; accumulator clears after a last beat.
// Reset: rst_n clears both pipeline stages, the accumulator and the registers
//   (16-bit mode, polynomial zero).
// Stall: when crc_out is not taken, the result register holds and the input
//   register still takes one more byte; further bytes see ready low.
module crc16_crc32_byte_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crcbe_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [crcbe_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [crcbe_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    crcbe_in_if.sink                          byte_in,
    crcbe_out_if.source                       crc_out
);

    crcbe_pkg::crc_cfg_t cfg;

    crcbe_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcbe_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .byte_in (byte_in),
        .crc_out (crc_out)
    );

endmodule

### bench/tb_crc16_crc32_byte_engine.sv
// Self-checking testbench for the CRC-16/CRC-32 byte engine
`timescale 1ns / 100ps

module tb_crc16_crc32_byte_engine;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [crcbe_pkg::APB_ADDR_W-1:0] ADDR_POLY  = {crcbe_pkg::REG_POLY, 2'b00};
    localparam logic [crcbe_pkg::APB_ADDR_W-1:0] ADDR_WIDTH = {crcbe_pkg::REG_WIDTH, 2'b00};

    typedef struct {
        logic [7:0] data;
        logic       last;
    } byte_beat_t;

    typedef struct {
        logic [31:0] crc;
        logic        done;
    } crc_beat_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [crcbe_pkg::APB_ADDR_W-1:0] paddr;
    logic [crcbe_pkg::APB_DATA_W-1:0] pwdata;
    logic [crcbe_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    crcbe_in_if  byte_if ();
    crcbe_out_if crc_if ();

    crc16_crc32_byte_engine i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .byte_in (byte_if),
        .crc_out (crc_if)
    );

    byte_beat_t byte_queue[$];
    crc_beat_t  crc_beats_due[$];

    // predictor state
    logic [31:0] crc_acc;
    logic [31:0] cfg_poly;
    logic        cfg_wide;

    logic        calm;
    int          src_idle;
    int          sink_idle;
    int          mismatches;
    int          beats_checked;
    int          msgs_checked;
    int          settings_done;
    int          cycles;
    byte_beat_t  next_beat;
    crc_beat_t   want;
    logic [31:0] crc_new;

    function automatic logic [31:0] crc_after_byte(
        input logic [31:0] acc,
        input logic [7:0]  data,
        input logic [31:0] poly,
        input logic        wide
    );
        logic [31:0] c32;
        logic [15:0] c16;
        int          k;
        if (wide)
        begin
            c32 = acc ^ {data, 24'h0};
            for (k = 0; k < 8; k++)
            begin
                if (c32[31])
                    c32 = {c32[30:0], 1'b0} ^ poly;
                else
                    c32 = {c32[30:0], 1'b0};
            end
            return c32;
        end
        c16 = acc[15:0] ^ {data, 8'h0};
        for (k = 0; k < 8; k++)
        begin
            if (c16[15])
                c16 = {c16[14:0], 1'b0} ^ poly[15:0];
            else
                c16 = {c16[14:0], 1'b0};
        end
        return {16'h0, c16};
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %h, got %h", what, exp_v, act_v);
    endtask

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("crc16_crc32_byte_engine verification failed");
            $finish;
        end
    end

    // byte driver, predicts on every accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_if.valid <= 1'b0;
        end
        else
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                crc_new = crc_after_byte(crc_acc, byte_if.data_byte, cfg_poly, cfg_wide);
                crc_beats_due.push_back('{crc_new, byte_if.last_byte});
                crc_acc = byte_if.last_byte ? 32'h0 : crc_new;
            end
            if (!byte_if.valid || byte_if.ready)
            begin
                if (src_idle > 0)
                begin
                    src_idle--;
                    byte_if.valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    next_beat = byte_queue.pop_front();
                    byte_if.data_byte <= next_beat.data;
                    byte_if.last_byte <= next_beat.last;
                    byte_if.valid     <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0)
                        src_idle = $urandom_range(1, 3);
                end
                else
                begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            crc_if.ready <= 1'b0;
        end
        else
        begin
            if (crc_if.valid && crc_if.ready)
            begin
                if (crc_beats_due.size() == 0)
                begin
                    note_mismatch("unexpected crc beat", 32'h0, crc_if.crc_value);
                end
                else
                begin
                    want = crc_beats_due.pop_front();
                    if (crc_if.crc_value !== want.crc)
                        note_mismatch("crc_value", want.crc, crc_if.crc_value);
                    if (crc_if.message_done !== want.done)
                        note_mismatch("message_done", {31'h0, want.done},
                                      {31'h0, crc_if.message_done});
                    beats_checked++;
                    if (want.done)
                        msgs_checked++;
                end
            end
            if (sink_idle > 0)
            begin
                sink_idle--;
                crc_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                sink_idle = $urandom_range(0, 2);
                crc_if.ready <= 1'b0;
            end
            else
            begin
                crc_if.ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input logic [crcbe_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [crcbe_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [31:0] exp_v);
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== exp_v)
            note_mismatch("register readback", exp_v, got);
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || byte_if.valid || crc_beats_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_crc_mode(input logic [31:0] poly, input logic [31:0] width_word);
        wait_drained();
        repeat (4) @(posedge clk);
        apb_write(ADDR_POLY, poly);
        apb_write(ADDR_WIDTH, width_word);
        cfg_poly = poly;
        cfg_wide = width_word[0];
        apb_read_check(ADDR_POLY, poly);
        apb_read_check(ADDR_WIDTH, {31'h0, width_word[0]});
        settings_done++;
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        byte_queue.push_back('{data, last});
    endtask

    task automatic push_messages(input int n_beats);
        int left;
        int len;
        int j;
        logic [7:0] d;
        left = n_beats;
        while (left > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
            for (j = 0; j < len && left > 0; j++)
            begin
                case ($urandom_range(0, 7))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = 8'($urandom);
                endcase
                push_byte(d, j == len - 1);
                left--;
            end
        end
    endtask

    initial
    begin
        logic [31:0] poly;
        logic [31:0] wword;
        int p;
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'h00;
        byte_if.last_byte = 1'b0;
        crc_if.ready      = 1'b0;
        crc_acc       = 32'h0;
        cfg_poly      = 32'h0;
        cfg_wide      = 1'b0;
        calm          = 1'b0;
        src_idle      = 0;
        sink_idle     = 0;
        mismatches    = 0;
        beats_checked = 0;
        msgs_checked  = 0;
        settings_done = 0;
        cycles        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: 16-bit, polynomial zero
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);

        set_crc_mode(32'h0000_1021, 32'h0);
        push_byte(8'h31, 1'b0);
        push_byte(8'h32, 1'b0);
        push_byte(8'h33, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b1);

        // all-ones polynomial, width word with every bit set
        set_crc_mode(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h01, 1'b1);

        // 32 -> 16 bit change mid-message, upper width bits masked
        set_crc_mode(32'h04C1_1DB7, 32'h1);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        set_crc_mode(32'h0000_8005, 32'hFFFF_FFFE);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        push_byte(8'h77, 1'b0);
        // 16 -> 32 bit change mid-message
        set_crc_mode(32'h04C1_1DB7, 32'h1);
        push_byte(8'h88, 1'b1);
        push_byte(8'h11, 1'b0);
        // polynomial change mid-message
        set_crc_mode(32'h1EDC_6F41, 32'h1);
        push_byte(8'h22, 1'b1);
        set_crc_mode(32'h0, 32'h1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h7F, 1'b1);

        for (p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 5))
                0:       poly = 32'h0;
                1:       poly = 32'hFFFF_FFFF;
                2:       poly = 32'h0000_1021;
                3:       poly = 32'h04C1_1DB7;
                default: poly = $urandom;
            endcase
            wword = $urandom;
            wword[0] = p[0];
            set_crc_mode(poly, wword);
            if (p == 7)
                calm = 1'b1;
            push_messages(119);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("%0d CRC beats checked in %0d complete messages", beats_checked, msgs_checked);
        $display("%0d register settings across 16- and 32-bit modes", settings_done);
        if (mismatches == 0)
            $display("crc16_crc32_byte_engine verification clean");
        else
            $display("crc16_crc32_byte_engine verification failed");
        $finish;
    end

endmodule

### crc16_crc32_byte_engine.f
+incdir+src
src/crcbe_pkg.sv
src/crcbe_if.sv
src/crcbe_cfg_regs.sv
src/crcbe_core.sv
src/crc16_crc32_byte_engine.sv
bench/tb_crc16_crc32_byte_engine.sv
